/* rtl/core/video_beam_timer_with_nmi_status_assert.svh */
// Assertion macros shared by the beam timer RTL
`ifndef VIDEO_BEAM_TIMER_WITH_NMI_STATUS_ASSERT_SVH
`define VIDEO_BEAM_TIMER_WITH_NMI_STATUS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define VBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vbt_pkg.sv */
// Types and constants of the video beam timer
package vbt_pkg;

  localparam int CYCLE_W = 7;
  localparam int LINE_W  = 9;
  localparam int DATA_W  = 8;
  localparam int ADDR_W  = 4;

  localparam logic [CYCLE_W-1:0] LINE_CYCLES        = 7'd114;
  localparam logic [CYCLE_W-1:0] STATUS_CYCLE       = 7'd6;
  localparam logic [CYCLE_W-1:0] COUNT_CYCLE        = 7'd111;
  localparam logic [CYCLE_W-1:0] SYNC_RELEASE_CYCLE = 7'd104;

  localparam logic [LINE_W-1:0] VBLANK_LINE      = 9'd248;
  localparam logic [LINE_W-1:0] FRAME_LINES_RST  = 9'd262;

  localparam logic [DATA_W-1:0] BIT_VBI   = 8'h40;
  localparam logic [DATA_W-1:0] BIT_DLI   = 8'h80;
  localparam logic [DATA_W-1:0] READ_NONE = 8'hFF;

  localparam logic [ADDR_W-1:0] REG_SYNC   = 4'hA;
  localparam logic [ADDR_W-1:0] REG_COUNT  = 4'hB;
  localparam logic [ADDR_W-1:0] REG_ENABLE = 4'hE;
  localparam logic [ADDR_W-1:0] REG_STATUS = 4'hF;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] write_data;
    logic              dma_busy;
  } item_t;

  typedef struct packed {
    logic               cpu_halted;
    logic [DATA_W-1:0]  read_data;
    logic               nmi_raised;
    logic [CYCLE_W-1:0] beam_cycle;
    logic [LINE_W-1:0]  beam_line;
  } result_t;

endpackage

/* rtl/core/vbt_if.sv */
// Valid/ready channel interfaces for commands and results
interface vbt_in_if import vbt_pkg::*; ();
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] write_data;
  logic              dma_busy;

  modport source (output valid, command, reg_addr, write_data, dma_busy, input ready);
  modport sink   (input valid, command, reg_addr, write_data, dma_busy, output ready);
endinterface

interface vbt_out_if import vbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cpu_halted;
  logic [DATA_W-1:0]  read_data;
  logic               nmi_raised;
  logic [CYCLE_W-1:0] beam_cycle;
  logic [LINE_W-1:0]  beam_line;

  modport source (output valid, cpu_halted, read_data, nmi_raised, beam_cycle, beam_line,
                  input ready);
  modport sink   (input valid, cpu_halted, read_data, nmi_raised, beam_cycle, beam_line,
                  output ready);
endinterface

/* rtl/core/vbt_core.sv */
// Beam counters, status/enable registers and per-item result logic
module vbt_core import vbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  item_t             item,
  input  logic [LINE_W-1:0] frame_lines,
  output result_t           res
);

  logic [CYCLE_W-1:0] cyc_r, cyc_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [DATA_W-1:0]  half_r, half_nxt;
  logic [DATA_W-1:0]  status_r, status_nxt;
  logic [DATA_W-1:0]  enable_r, enable_nxt;
  logic               armed_r, armed_nxt;

  logic [CYCLE_W-1:0] cyc_inc;
  logic [LINE_W-1:0]  line_inc;
  logic               vbi_hit;

  assign cyc_inc  = cyc_r + 7'd1;
  assign line_inc = line_r + 9'd1;
  assign vbi_hit  = (cyc_r == STATUS_CYCLE) && (line_r == VBLANK_LINE);

  always_comb begin
    cyc_nxt    = cyc_r;
    line_nxt   = line_r;
    half_nxt   = half_r;
    status_nxt = status_r;
    enable_nxt = enable_r;
    armed_nxt  = armed_r;
    res        = '0;
    case (item.command)
      CMD_TICK: begin
        if (vbi_hit) begin
          status_nxt     = (status_r & ~BIT_DLI) | BIT_VBI;
          res.nmi_raised = |(enable_r & BIT_VBI);
        end
        if ((cyc_r == COUNT_CYCLE) && line_r[0]) begin
          half_nxt = half_r + 8'd1;
        end
        if (armed_r) begin
          if (cyc_r == SYNC_RELEASE_CYCLE) begin
            armed_nxt = 1'b0;
          end else begin
            res.cpu_halted = 1'b1;
          end
        end
        if (item.dma_busy) begin
          res.cpu_halted = 1'b1;
        end
        cyc_nxt = cyc_inc;
        // cyc_inc of zero means the 7-bit count rolled over
        if ((cyc_inc >= LINE_CYCLES) || (cyc_inc == '0)) begin
          cyc_nxt  = '0;
          line_nxt = line_inc;
          if ((line_inc >= frame_lines) || (line_inc == '0)) begin
            line_nxt = '0;
            half_nxt = '0;
          end
        end
      end
      CMD_READ: begin
        case (item.reg_addr)
          REG_COUNT:  res.read_data = half_r;
          REG_STATUS: res.read_data = status_r;
          default:    res.read_data = READ_NONE;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_addr)
          REG_SYNC:   armed_nxt  = 1'b1;
          REG_ENABLE: enable_nxt = item.write_data;
          REG_STATUS: status_nxt = '0;
          default:    ;
        endcase
      end
      default: ;
    endcase
    res.beam_cycle = cyc_nxt;
    res.beam_line  = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r    <= '0;
      line_r   <= '0;
      half_r   <= '0;
      status_r <= '0;
      enable_r <= '0;
      armed_r  <= 1'b0;
    end else if (step) begin
      cyc_r    <= cyc_nxt;
      line_r   <= line_nxt;
      half_r   <= half_nxt;
      status_r <= status_nxt;
      enable_r <= enable_nxt;
      armed_r  <= armed_nxt;
    end
  end

`include "video_beam_timer_with_nmi_status_assert.svh"

  `VBT_ASSERT_NOW(a_cycle_range, 1'b1, cyc_r < LINE_CYCLES, "beam cycle past end of line")
  `VBT_ASSERT_NOW(a_wait_release, $past(rst_n) && $fell(armed_r), $past(cyc_r) == SYNC_RELEASE_CYCLE, "sync wait dropped off the release cycle")
  `VBT_ASSERT_NOW(a_vbi_source, $past(rst_n) && $rose(status_r[6]), $past(vbi_hit), "vblank status set outside its slot")

endmodule

/* rtl/core/video_beam_timer_with_nmi_status.sv */
// Video beam timer top level: command register, result register, config
// Usage:
//   in_bus carries one command per beat: a tick (one machine cycle of the
//   beam), a register read or a register write, with dma_busy for ticks.
//   out_bus returns exactly one result beat per command: halt flag, read
//   byte, NMI pulse and the beam position after the command.
//   cfg_we/cfg_wdata load the frame length in lines; write it only while
//   no command is in flight.
// Path: an accepted beat is registered in the command register, then processed
//   into the result register and offered on out_bus from then on.
// Throughput: one beat per cycle while out_bus.ready is high; the per-command logic is
//   a single combinational pass from the command register into the result register.
// Reset (rst_n low, synchronous): beam at cycle 0 line 0, counters, status,
//   enable and sync wait cleared, frame length 262, both stages empty.
// Stall: while out_bus.ready is low the result register holds; the command
//   register still takes one more beat, then in_bus.ready drops until the
//   result is taken.
module video_beam_timer_with_nmi_status import vbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vbt_in_if.sink            in_bus,
  vbt_out_if.source         out_bus,
  input  logic              cfg_we,
  input  logic [LINE_W-1:0] cfg_wdata
);

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  result_t           core_res;
  logic [LINE_W-1:0] frame_lines_r;
  logic              advance;
  logic              in_take;

  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      frame_lines_r <= FRAME_LINES_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        frame_lines_r <= cfg_wdata;
      end
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.command    <= in_bus.command;
      s1_item_r.reg_addr   <= in_bus.reg_addr;
      s1_item_r.write_data <= in_bus.write_data;
      s1_item_r.dma_busy   <= in_bus.dma_busy;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  vbt_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (s1_item_r),
    .frame_lines (frame_lines_r),
    .res         (core_res)
  );

  assign out_bus.valid      = out_valid_r;
  assign out_bus.cpu_halted = out_res_r.cpu_halted;
  assign out_bus.read_data  = out_res_r.read_data;
  assign out_bus.nmi_raised = out_res_r.nmi_raised;
  assign out_bus.beam_cycle = out_res_r.beam_cycle;
  assign out_bus.beam_line  = out_res_r.beam_line;

`include "video_beam_timer_with_nmi_status_assert.svh"

  `VBT_ASSERT_NEXT(a_stage_hold, s1_valid_r && out_valid_r && !out_bus.ready, s1_valid_r && out_valid_r, "pending beat lost during output stall")

endmodule

/* bench/video_beam_timer_with_nmi_status_test.sv */
// Self-checking testbench for the video beam timer: random and directed commands
`timescale 1ns / 100ps

module video_beam_timer_with_nmi_status_test;
  import vbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int          WALK_TICKS  = 150;  // a tick-heavy stretch of a line or so
  localparam int          HOLD_CYCLES = 300;

  // Tracks the beam, counters and status; keeps the results still owed by the block.
  class beam_timer_tracker;
    logic [LINE_W-1:0]  frame_lines;
    logic [CYCLE_W-1:0] cycle_pos;
    logic [LINE_W-1:0]  line_pos;
    logic [DATA_W-1:0]  half_lines;
    logic [DATA_W-1:0]  status;
    logic [DATA_W-1:0]  enable;
    bit                 wait_armed;
    result_t            pending_results[$];
    int                 mismatches;
    int                 ticks;
    int                 vblank_hits;
    int                 nmi_count;
    int                 halted_count;
    int                 checked;

    function new();
      frame_lines = FRAME_LINES_RST;
      cycle_pos   = '0;
      line_pos    = '0;
      half_lines  = '0;
      status      = '0;
      enable      = '0;
      wait_armed  = 1'b0;
    endfunction

    function void note_command(item_t it);
      result_t            res;
      logic [CYCLE_W-1:0] next_cycle;
      logic [LINE_W-1:0]  next_line;
      res = '0;
      case (it.command)
        CMD_TICK: begin
          ticks++;
          if (cycle_pos == STATUS_CYCLE && line_pos == VBLANK_LINE) begin
            status = (status & ~BIT_DLI) | BIT_VBI;
            vblank_hits++;
            if ((enable & BIT_VBI) != 0) begin
              res.nmi_raised = 1'b1;
              nmi_count++;
            end
          end
          if (cycle_pos == COUNT_CYCLE && line_pos[0])
            half_lines = half_lines + 8'd1;
          if (wait_armed) begin
            if (cycle_pos == SYNC_RELEASE_CYCLE) wait_armed = 1'b0;
            else res.cpu_halted = 1'b1;
          end
          if (it.dma_busy) res.cpu_halted = 1'b1;
          if (res.cpu_halted) halted_count++;
          next_cycle = cycle_pos + 7'd1;
          if (next_cycle >= LINE_CYCLES || next_cycle == '0) begin
            next_cycle = '0;
            next_line  = line_pos + 9'd1;
            // short frame: a length below the current line wraps here too
            if (next_line >= frame_lines || next_line == '0) begin
              next_line  = '0;
              half_lines = '0;
            end
            line_pos = next_line;
          end
          cycle_pos = next_cycle;
        end
        CMD_READ: begin
          if (it.reg_addr == REG_COUNT)       res.read_data = half_lines;
          else if (it.reg_addr == REG_STATUS) res.read_data = status;
          else                                res.read_data = READ_NONE;
        end
        CMD_WRITE: begin
          if (it.reg_addr == REG_SYNC)        wait_armed = 1'b1;
          else if (it.reg_addr == REG_ENABLE) enable = it.write_data;
          else if (it.reg_addr == REG_STATUS) status = '0;
        end
        default: ;  // unused command: only the beam position comes back
      endcase
      res.beam_cycle = cycle_pos;
      res.beam_line  = line_pos;
      pending_results.push_back(res);
    endfunction

    function void report_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_val, got_val);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %p", $time, got);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if ($isunknown(got)) begin
        $display("%0t: unknown bits in result, expected %p, got %p", $time, exp, got);
        mismatches++;
        return;
      end
      report_field("cpu_halted", int'(exp.cpu_halted), int'(got.cpu_halted));
      report_field("read_data", int'(exp.read_data), int'(got.read_data));
      report_field("nmi_raised", int'(exp.nmi_raised), int'(got.nmi_raised));
      report_field("beam_cycle", int'(exp.beam_cycle), int'(got.beam_cycle));
      report_field("beam_line", int'(exp.beam_line), int'(got.beam_line));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LINE_W-1:0] cfg_wdata;

  vbt_in_if  in_bus ();
  vbt_out_if out_bus ();

  video_beam_timer_with_nmi_status dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  beam_timer_tracker tracker;
  int unsigned       cycle_count;
  bit                hold_request;
  int                hold_left;
  int                stall_mode;
  int                stall_left;
  int                burst_left;
  int                beats_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               tracker.pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      tracker.check_result({out_bus.cpu_halted, out_bus.read_data, out_bus.nmi_raised,
                            out_bus.beam_cycle, out_bus.beam_line});
    end
  end

  // receiver: a long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= 1'($urandom_range(0, 1));
        2:       out_bus.ready <= (cycle_count % 5) != 0;
        default: out_bus.ready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  function automatic item_t make_item(cmd_t c, logic [ADDR_W-1:0] a,
                                      logic [DATA_W-1:0] d, logic b);
    item_t it;
    it.command    = c;
    it.reg_addr   = a;
    it.write_data = d;
    it.dma_busy   = b;
    return it;
  endfunction

  // sender idles between bursts; some bursts are long stretches with no gaps
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 30);
    return $urandom_range(1, 5);
  endfunction

  function automatic item_t random_command();
    int                r;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic              b;
    r = $urandom_range(0, 99);
    a = ADDR_W'($urandom_range(0, 15));
    d = DATA_W'($urandom_range(0, 255));
    b = 1'($urandom_range(0, 1));
    if (r < 60)
      return make_item(CMD_TICK, a, d, b);
    if (r < 75) begin
      if ($urandom_range(0, 1)) a = $urandom_range(0, 1) ? REG_COUNT : REG_STATUS;
      return make_item(CMD_READ, a, d, b);
    end
    if (r < 92) begin
      case ($urandom_range(0, 3))
        0:       a = REG_SYNC;
        1:       a = REG_ENABLE;
        2:       a = REG_STATUS;
        default: ;
      endcase
      return make_item(CMD_WRITE, a, d, b);
    end
    return make_item(cmd_t'(2'd3), a, d, b);
  endfunction

  // mostly ticks, so the beam keeps moving; enable left alone
  function automatic item_t frame_command();
    int                r;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic              b;
    r = $urandom_range(0, 99);
    a = ADDR_W'($urandom_range(0, 15));
    d = DATA_W'($urandom_range(0, 255));
    b = 1'($urandom_range(0, 1));
    if (r < 96)
      return make_item(CMD_TICK, a, d, $urandom_range(0, 3) == 0);
    if (r < 98) begin
      if ($urandom_range(0, 3) != 0) a = $urandom_range(0, 1) ? REG_COUNT : REG_STATUS;
      return make_item(CMD_READ, a, d, b);
    end
    a = $urandom_range(0, 1) ? REG_SYNC : REG_STATUS;
    return make_item(CMD_WRITE, a, d, b);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_command(input item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.command    <= it.command;
    in_bus.reg_addr   <= it.reg_addr;
    in_bus.write_data <= it.write_data;
    in_bus.dma_busy   <= it.dma_busy;
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_command(it);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frame_lines(input logic [LINE_W-1:0] lines);
    cfg_we    <= 1'b1;
    cfg_wdata <= lines;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.frame_lines = lines;
  endtask

  task automatic run_random(input logic [LINE_W-1:0] lines, input int count,
                            input bit with_hold);
    drain();
    write_frame_lines(lines);
    if (with_hold) hold_request = 1'b1;
    repeat (count) send_command(random_command());
  endtask

  // tick-heavy stretch of the beam with a given interrupt enable
  task automatic run_frame(input logic [LINE_W-1:0] lines, input logic [DATA_W-1:0] en);
    item_t it;
    int    walked;
    walked = 0;
    drain();
    write_frame_lines(lines);
    send_command(make_item(CMD_WRITE, REG_ENABLE, en, 1'b0));
    while (walked < WALK_TICKS) begin
      it = frame_command();
      send_command(it);
      if (it.command == CMD_TICK) walked++;
    end
  endtask

  initial begin
    tracker      = new();
    cycle_count  = 0;
    hold_request = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    burst_left   = 0;
    beats_sent   = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_bus.valid      = 1'b0;
    in_bus.command    = CMD_TICK;
    in_bus.reg_addr   = '0;
    in_bus.write_data = '0;
    in_bus.dma_busy   = 1'b0;
    out_bus.ready     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset values, every register, unused command, wait and dma
    send_command(make_item(CMD_READ, REG_COUNT, 8'h00, 1'b0));
    send_command(make_item(CMD_READ, REG_STATUS, 8'hFF, 1'b1));
    send_command(make_item(CMD_READ, 4'h0, 8'h00, 1'b0));
    send_command(make_item(CMD_READ, REG_ENABLE, 8'h00, 1'b0));
    send_command(make_item(CMD_TICK, 4'h0, 8'h00, 1'b0));
    send_command(make_item(CMD_TICK, 4'hF, 8'hFF, 1'b1));
    send_command(make_item(CMD_WRITE, REG_ENABLE, 8'h40, 1'b0));
    send_command(make_item(CMD_WRITE, REG_ENABLE, 8'hFF, 1'b1));
    send_command(make_item(CMD_WRITE, REG_STATUS, 8'h00, 1'b0));
    send_command(make_item(CMD_WRITE, 4'h5, 8'hA5, 1'b0));
    send_command(make_item(CMD_WRITE, 4'hB, 8'h5A, 1'b1));
    send_command(make_item(cmd_t'(2'd3), REG_STATUS, 8'hFF, 1'b1));
    send_command(make_item(cmd_t'(2'd3), 4'h0, 8'h00, 1'b0));
    send_command(make_item(CMD_WRITE, REG_SYNC, 8'h00, 1'b0));
    send_command(make_item(CMD_TICK, 4'h0, 8'h00, 1'b0));
    send_command(make_item(CMD_WRITE, REG_SYNC, 8'hFF, 1'b0));
    send_command(make_item(CMD_TICK, 4'h0, 8'h00, 1'b1));
    send_command(make_item(CMD_TICK, 4'h0, 8'h00, 1'b0));
    send_command(make_item(CMD_READ, 4'hF, 8'h00, 1'b0));
    send_command(make_item(CMD_READ, 4'h1, 8'h00, 1'b0));

    run_random(FRAME_LINES_RST, 200, 1'b1);
    run_frame(9'd250, 8'hFF);  // NMI enabled
    run_random(9'd5, 150, 1'b0);
    run_random(9'd2, 150, 1'b0);  // shorter than the current line
    run_random(9'd1, 100, 1'b0);
    run_random(9'd0, 100, 1'b0);
    run_random(9'd3, 150, 1'b0);
    run_random(9'd511, 200, 1'b1);
    run_frame(FRAME_LINES_RST, 8'hBF);  // vertical-blank enable clear
    run_random(9'd7, 100, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d beats (%0d ticks), checked %0d results, frame lengths 0 to 511",
             beats_sent, tracker.ticks, tracker.checked);
    $display("Saw %0d vertical-blank events, %0d NMIs, %0d halted cycles",
             tracker.vblank_hits, tracker.nmi_count, tracker.halted_count);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/vbt_pkg.sv
rtl/core/vbt_if.sv
rtl/core/vbt_core.sv
rtl/core/video_beam_timer_with_nmi_status.sv
bench/video_beam_timer_with_nmi_status_test.sv
